@@ design/prw_pkg.sv @@
// Shared types and constants for the particle resampling wheel.
package prw_pkg;

	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int WEIGHT_BITS_DEF   = 16;

	localparam int COMMAND_BITS = 2;
	localparam int FIELD_BITS   = 16;
	localparam int RAND_BITS    = 16;
	localparam int COUNT_BITS   = 11;
	localparam int INDEX_BITS   = 10;

	localparam logic [COUNT_BITS-1:0] RESET_COUNT = COUNT_BITS'(1024);

	typedef enum logic [COMMAND_BITS-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_DRAW  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SEED,
		ST_ADD,
		ST_MOD,
		ST_READ,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

@@ design/particle_resampling_wheel_top.sv @@
// Resampling wheel for a particle filter: weight store, shared multiplier and walk sequencer.
//
// A load beat is written to the store on acceptance while the store has room; a start beat
// goes through accept, multiply and seed. A draw beat walks k steps, where k is the number
// of weights the wheel steps over; each step is one read of the weight memory, and the walk
// is capped at three times the particle count. If the particle count is at or below the
// stored wheel position, the position is first reduced by a bit-serial remainder. The single
// multiplier is shared by the start seed and the draw increment. A finished result sits in
// an output register, so the next command beat is taken while it waits.
module particle_resampling_wheel_top #(
	parameter int MAX_PARTICLES = prw_pkg::MAX_PARTICLES_DEF,
	parameter int WEIGHT_BITS   = prw_pkg::WEIGHT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [prw_pkg::COUNT_BITS-1:0]    cfg_wdata,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [prw_pkg::COMMAND_BITS-1:0]  command,
	input  logic [prw_pkg::FIELD_BITS-1:0]    weight,
	input  logic [prw_pkg::RAND_BITS-1:0]     rand_fraction,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [prw_pkg::INDEX_BITS-1:0]    particle_index
);
	import prw_pkg::*;

	localparam int IDXW  = $clog2(MAX_PARTICLES);
	localparam int PTRW  = $clog2(MAX_PARTICLES + 1);
	localparam int CW    = (PTRW > COUNT_BITS) ? PTRW : COUNT_BITS;
	localparam int BETAW = WEIGHT_BITS + 2;
	localparam int MB    = (PTRW > WEIGHT_BITS) ? PTRW : WEIGHT_BITS;
	localparam int PW    = RAND_BITS + MB;
	localparam int SW    = PTRW + 2;
	localparam int CNTW  = $clog2(IDXW + 1);
	localparam logic [BETAW-1:0] BETA_MAX = '1;

	state_t                 state_q, state_d;
	cmd_t                   cmd_in, cmd_q;
	logic                   accept;
	logic                   mem_we;
	logic [IDXW-1:0]        rd_addr;
	logic                   res_load;

	logic [WEIGHT_BITS-1:0] mem [MAX_PARTICLES];
	logic [WEIGHT_BITS-1:0] rdata_q;

	logic [COUNT_BITS-1:0]  count_q;
	logic [PTRW-1:0]        load_ptr_q;
	logic [WEIGHT_BITS-1:0] max_q;
	logic [IDXW-1:0]        wheel_q;
	logic [BETAW-1:0]       beta_q;
	logic                   res_valid_q;
	logic [INDEX_BITS-1:0]  index_q;

	logic [RAND_BITS-1:0]   rand_q;
	logic [PW-1:0]          prod_q;
	logic [PTRW:0]          rem_q;
	logic [CNTW-1:0]        cnt_q;
	logic [SW-1:0]          steps_q;
	logic [SW-1:0]          limit_q;

	logic [CW-1:0]          count_ext;
	logic [PTRW-1:0]        n_w;
	logic [WEIGHT_BITS-1:0] w_in;
	logic                   ptr_room;
	logic [MB-1:0]          mul_b;
	logic [BETAW:0]         beta_sum;
	logic [BETAW-1:0]       beta_sat;
	logic                   wrap_needed;
	logic [PTRW:0]          rem_shift;
	logic [PTRW:0]          rem_next;
	logic                   mod_last;
	logic                   walk_step;
	logic [PTRW-1:0]        wheel_inc;
	logic [IDXW-1:0]        wheel_nxt;
	logic [SW-1:0]          limit_w;

	assign cmd_in    = cmd_t'(command);
	assign count_ext = CW'(count_q);

	// A count of zero behaves as one, and a count beyond the store is clipped to it.
	always_comb begin
		priority if (count_q == '0) begin
			n_w = PTRW'(1);
		end else if (count_ext > CW'(MAX_PARTICLES)) begin
			n_w = PTRW'(MAX_PARTICLES);
		end else begin
			n_w = PTRW'(count_ext);
		end
	end

	assign w_in     = WEIGHT_BITS'(weight);
	assign ptr_room = load_ptr_q < PTRW'(MAX_PARTICLES);
	assign mul_b    = (cmd_q == CMD_START) ? MB'(n_w) : MB'(max_q);

	// The increment is rand * 2 * max, which drops one bit fewer than the rand scale.
	assign beta_sum = (BETAW+1)'(beta_q) +
		(BETAW+1)'(prod_q[RAND_BITS-1 +: WEIGHT_BITS+1]);
	assign beta_sat = beta_sum[BETAW] ? BETA_MAX : beta_sum[BETAW-1:0];

	assign wrap_needed = PTRW'(wheel_q) >= n_w;
	assign rem_shift   = {rem_q[PTRW-1:0], wheel_q[IDXW-1]};
	assign rem_next    = (rem_shift >= {1'b0, n_w}) ? (rem_shift - {1'b0, n_w}) : rem_shift;
	assign mod_last    = cnt_q == CNTW'(IDXW - 1);

	assign walk_step = (steps_q < limit_q) && (beta_q > BETAW'(rdata_q));
	assign wheel_inc = PTRW'(wheel_q) + PTRW'(1);
	assign wheel_nxt = (wheel_inc == n_w) ? '0 : wheel_inc[IDXW-1:0];
	assign limit_w   = SW'({n_w, 1'b0}) + SW'(n_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		accept    = 1'b0;
		mem_we    = 1'b0;
		rd_addr   = wheel_q;
		res_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				accept    = cmd_valid;
				if (cmd_valid) begin
					unique case (cmd_in)
						CMD_LOAD:  mem_we = ptr_room;
						CMD_START: state_d = ST_MUL;
						CMD_DRAW:  state_d = ST_MUL;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				state_d = (cmd_q == CMD_START) ? ST_SEED : ST_ADD;
			end
			ST_SEED: begin
				state_d = ST_IDLE;
			end
			ST_ADD: begin
				state_d = wrap_needed ? ST_MOD : ST_READ;
			end
			ST_MOD: begin
				if (mod_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				// Read ahead at the next wheel slot so a step completes every cycle.
				if (walk_step) begin
					rd_addr = wheel_nxt;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_ptr_q[IDXW-1:0]] <= w_in;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= CMD_LOAD;
			count_q     <= RESET_COUNT;
			load_ptr_q  <= '0;
			max_q       <= '0;
			wheel_q     <= '0;
			beta_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				count_q <= cfg_wdata;
			end
			if (accept) begin
				cmd_q <= cmd_in;
				if (cmd_in == CMD_START) begin
					load_ptr_q <= '0;
					beta_q     <= '0;
				end
			end
			if (mem_we) begin
				if (load_ptr_q == '0 || w_in > max_q) begin
					max_q <= w_in;
				end
				load_ptr_q <= load_ptr_q + PTRW'(1);
			end
			unique case (state_q)
				ST_SEED: wheel_q <= prod_q[RAND_BITS +: IDXW];
				ST_ADD:  beta_q <= beta_sat;
				ST_MOD: begin
					if (mod_last) begin
						wheel_q <= rem_next[IDXW-1:0];
					end else begin
						wheel_q <= wheel_q << 1;
					end
				end
				ST_WALK: begin
					if (walk_step) begin
						beta_q  <= beta_q - BETAW'(rdata_q);
						wheel_q <= wheel_nxt;
					end
				end
				default: ;
			endcase
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rand_q <= rand_fraction;
		end
		unique case (state_q)
			ST_MUL:  prod_q <= PW'(rand_q) * PW'(mul_b);
			ST_ADD: begin
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_MOD: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q + CNTW'(1);
			end
			ST_READ: begin
				steps_q <= '0;
				limit_q <= limit_w;
			end
			ST_WALK: begin
				if (walk_step) begin
					steps_q <= steps_q + SW'(1);
				end
			end
			default: ;
		endcase
		if (res_load) begin
			index_q <= INDEX_BITS'(wheel_q);
		end
	end

	assign res_valid      = res_valid_q;
	assign particle_index = index_q;

	// The wheel sits inside the active particle range whenever a result is formed.
	a_wheel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> PTRW'(wheel_q) < n_w)
		else $error("wheel index outside particle count at result");

	// The walk never runs past its step cap.
	a_steps_capped: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> steps_q <= limit_q)
		else $error("walk exceeded its step cap");

	// The load pointer never passes the store depth.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_ptr_q <= PTRW'(MAX_PARTICLES))
		else $error("load pointer beyond store depth");

	// The partial remainder stays below the modulus throughout the reduction.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD && cnt_q != '0 |-> rem_q < {1'b0, n_w})
		else $error("remainder not below particle count");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the particle resampling wheel: directed table, then random phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prw_pkg::*;

	localparam int MAXP = MAX_PARTICLES_DEF;
	localparam longint unsigned BETA_MAX = (64'd1 << (WEIGHT_BITS_DEF + 2)) - 1;
	localparam logic [COMMAND_BITS-1:0] CMD_UNKNOWN = 2'd3;
	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 20000;

	typedef enum {ROW_BEAT, ROW_SETCOUNT} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [COMMAND_BITS-1:0] op;
		logic [FIELD_BITS-1:0]  w;
		logic [RAND_BITS-1:0]   r;
		logic [COUNT_BITS-1:0]  countv;
		bit                     known;
		logic [INDEX_BITS-1:0]  want;
	} row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wen = 1'b0;
	logic [COUNT_BITS-1:0]   cfg_wdata = '0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_stall;
	logic [COMMAND_BITS-1:0] command = CMD_LOAD;
	logic [FIELD_BITS-1:0]   weight = '0;
	logic [RAND_BITS-1:0]    rand_fraction = '0;
	logic                    res_valid;
	logic                    res_stall = 1'b0;
	logic [INDEX_BITS-1:0]   particle_index;

	// Own copy of the wheel state, updated on every accepted beat.
	logic [FIELD_BITS-1:0]   w_store [MAXP];
	int                      fill_ptr = 0;
	logic [FIELD_BITS-1:0]   peak_w = '0;
	int                      wheel_pos = 0;
	logic [17:0]             beta_q = '0;
	logic [COUNT_BITS-1:0]   count_reg = RESET_COUNT;

	logic [INDEX_BITS-1:0]   picks_due [$];
	row_t                    script [$];
	int                      errors = 0;
	int                      useful_beats = 0;
	int                      burst_left = 0;
	bit                      hold_req = 1'b0;
	bit                      drv_known = 1'b0;
	logic [INDEX_BITS-1:0]   drv_expect = '0;

	particle_resampling_wheel_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.weight        (weight),
		.rand_fraction (rand_fraction),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.particle_index(particle_index)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int active_of(input logic [COUNT_BITS-1:0] v);
		if (v == 0) return 1;
		if (v > MAXP) return MAXP;
		return int'(v);
	endfunction

	function automatic bit wheel_step(input logic [COMMAND_BITS-1:0] op,
			input logic [FIELD_BITS-1:0] w, input logic [RAND_BITS-1:0] r,
			output logic [INDEX_BITS-1:0] pick);
		int n;
		int pos;
		int steps;
		longint unsigned b;
		n = active_of(count_reg);
		pick = '0;
		case (op)
		CMD_LOAD: begin
			if (fill_ptr < MAXP) begin
				w_store[fill_ptr] = w;
				if (fill_ptr == 0 || w > peak_w) peak_w = w;
				fill_ptr++;
			end
			return 1'b0;
		end
		CMD_START: begin
			wheel_pos = int'((longint'(r) * n) >> 16);
			beta_q = '0;
			fill_ptr = 0;
			return 1'b0;
		end
		CMD_DRAW: begin
			b = beta_q + ((longint'(r) * peak_w) >> 15);
			if (b > BETA_MAX) b = BETA_MAX;
			pos = wheel_pos % n;
			steps = 0;
			// The walk is capped, so a wheel of light weights keeps its leftover beta.
			while (steps < 3 * n && b > w_store[pos]) begin
				b -= w_store[pos];
				pos = (pos + 1 == n) ? 0 : pos + 1;
				steps++;
			end
			beta_q = b[17:0];
			wheel_pos = pos;
			pick = pos[INDEX_BITS-1:0];
			return 1'b1;
		end
		default: return 1'b0;
		endcase
	endfunction

	task automatic report(input string what, input logic [INDEX_BITS-1:0] got,
			input logic [INDEX_BITS-1:0] want);
		$display("tb: mismatch, %s: got %0d, want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk) begin : scoreboard
		logic [INDEX_BITS-1:0] pick;
		logic [INDEX_BITS-1:0] want;
		if (arst_n) begin
			if (cfg_wen) count_reg = cfg_wdata;
			if (cmd_valid && !cmd_stall) begin
				if (command != CMD_UNKNOWN && !(command == CMD_LOAD && fill_ptr >= MAXP))
					useful_beats++;
				if (wheel_step(command, weight, rand_fraction, pick))
					picks_due.insert(picks_due.size(), drv_known ? drv_expect : pick);
			end
			if (res_valid && !res_stall) begin
				if (picks_due.size() == 0) begin
					report("result with nothing expected", particle_index, 'x);
				end else begin
					want = picks_due.pop_front();
					if (particle_index !== want) report("particle_index", particle_index, want);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) quiet = 0;
			else quiet++;
		end
		$display("tb: done, errors");
		$finish;
	end

	// Receiver: segments of differing stall patterns, plus a long hold-off on request.
	initial begin : receiver
		int mode;
		int len;
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				@(negedge clk);
				res_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(10, 150);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
				0: res_stall = 1'b0;
				1: res_stall = 1'($urandom_range(0, 1));
				2: res_stall = ($urandom_range(0, 4) != 0);
				default: res_stall = (k % 3 == 0);
				endcase
			end
		end
	end

	function automatic logic [FIELD_BITS-1:0] rnd_weight();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return FIELD_BITS'($urandom_range(0, 255));
		default: return FIELD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [RAND_BITS-1:0] rnd_frac();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return RAND_BITS'($urandom);
		endcase
	endfunction

	function automatic row_t beat(input logic [COMMAND_BITS-1:0] op,
			input logic [FIELD_BITS-1:0] w, input logic [RAND_BITS-1:0] r,
			input bit known, input logic [INDEX_BITS-1:0] want);
		row_t t;
		t.kind = ROW_BEAT;
		t.op = op;
		t.w = w;
		t.r = r;
		t.countv = '0;
		t.known = known;
		t.want = want;
		return t;
	endfunction

	function automatic row_t setcount(input logic [COUNT_BITS-1:0] v);
		row_t t;
		t = beat(CMD_LOAD, '0, '0, 1'b0, '0);
		t.kind = ROW_SETCOUNT;
		t.countv = v;
		return t;
	endfunction

	function automatic void add_row(input row_t t);
		script.insert(script.size(), t);
	endfunction

	// Offers one command beat and holds it until accepted, then paces the next one.
	task automatic offer(input logic [COMMAND_BITS-1:0] op, input logic [FIELD_BITS-1:0] w,
			input logic [RAND_BITS-1:0] r, input bit known, input logic [INDEX_BITS-1:0] want);
		int gap;
		@(negedge clk);
		cmd_valid = 1'b1;
		command = op;
		weight = w;
		rand_fraction = r;
		drv_known = known;
		drv_expect = want;
		do @(posedge clk); while (cmd_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			cmd_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 12);
		end
	endtask

	// Waits until every expected pick has come out and the block has gone quiet.
	task automatic settle();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (picks_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [COUNT_BITS-1:0] v);
		settle();
		cfg_wen = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	initial begin : stimulus
		int i;
		int j;
		int base;
		int n;
		int nseq;
		int nload;
		int ndraw;
		int sel;
		bit half_done;
		logic [COUNT_BITS-1:0] cv;
		row_t t;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Every store entry is written before the first draw; the two extra loads hit a full store.
		offer(CMD_START, rnd_weight(), rnd_frac(), 1'b0, '0);
		for (i = 0; i < MAXP + 2; i++)
			offer(CMD_LOAD, rnd_weight(), RAND_BITS'($urandom), 1'b0, '0);

		add_row(beat(CMD_START, 16'h0000, 16'h0000, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'h0000, 1'b1, 10'd0));
		add_row(beat(CMD_START, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'hFFFF, 16'h0000, 1'b1, 10'd1023));
		add_row(beat(CMD_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b0, '0));
		// The wheel sits at 1023 while the count drops to five.
		add_row(setcount(11'd5));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(setcount(11'd0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b1, 10'd0));
		add_row(beat(CMD_START, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(beat(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, '0));
		add_row(beat(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, '0));
		add_row(beat(CMD_LOAD, 16'hFFFF, 16'h0000, 1'b0, '0));
		// Two zero weights in use against a large maximum: the walk runs away and beta saturates.
		add_row(setcount(11'd2));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(beat(CMD_START, 16'h0000, 16'h0000, 1'b0, '0));
		add_row(beat(CMD_LOAD, 16'h0001, 16'h0000, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));
		add_row(setcount(11'd2047));
		add_row(beat(CMD_START, 16'h0000, 16'h8000, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'h0001, 1'b0, '0));
		add_row(beat(CMD_DRAW, 16'h0000, 16'hFFFF, 1'b0, '0));

		foreach (script[i]) begin
			t = script[i];
			if (t.kind == ROW_SETCOUNT) write_count(t.countv);
			else offer(t.op, t.w, t.r, t.known, t.want);
		end

		base = useful_beats;
		half_done = 1'b0;
		hold_req = 1'b1;
		while (useful_beats - base < RANDOM_ITEMS) begin
			if (!half_done && useful_beats - base > RANDOM_ITEMS / 2) begin
				half_done = 1'b1;
				hold_req = 1'b1;
			end
			sel = $urandom_range(0, 19);
			case (sel)
			0: cv = 11'd0;
			1: cv = 11'd2047;
			2: cv = 11'd1024;
			3: cv = 11'd1;
			4: cv = COUNT_BITS'($urandom_range(1025, 2047));
			5: cv = COUNT_BITS'($urandom_range(65, 1023));
			6, 7, 8: cv = COUNT_BITS'($urandom_range(17, 64));
			default: cv = COUNT_BITS'($urandom_range(2, 16));
			endcase
			write_count(cv);
			n = active_of(cv);
			nseq = $urandom_range(1, 4);
			for (i = 0; i < nseq; i++) begin
				case ($urandom_range(0, 9))
				0: begin
					// Noise: any command code with arbitrary fields.
					for (j = $urandom_range(1, 6); j > 0; j--)
						offer(COMMAND_BITS'($urandom_range(0, 3)), FIELD_BITS'($urandom),
							RAND_BITS'($urandom), 1'b0, '0);
				end
				1: begin
					// Broken sequence: loads and draws with no start in front.
					for (j = $urandom_range(1, 8); j > 0; j--)
						offer($urandom_range(0, 1) ? CMD_LOAD : CMD_DRAW, rnd_weight(),
							rnd_frac(), 1'b0, '0);
				end
				default: begin
					offer(CMD_START, FIELD_BITS'($urandom), rnd_frac(), 1'b0, '0);
					if (n <= 64) nload = n + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
					else nload = $urandom_range(1, 24);
					for (j = 0; j < nload; j++) begin
						offer(CMD_LOAD, rnd_weight(), RAND_BITS'($urandom), 1'b0, '0);
						if ($urandom_range(0, 15) == 0)
							offer(CMD_UNKNOWN, FIELD_BITS'($urandom), RAND_BITS'($urandom),
								1'b0, '0);
					end
					ndraw = $urandom_range(1, 10);
					for (j = 0; j < ndraw; j++) begin
						offer(CMD_DRAW, FIELD_BITS'($urandom), rnd_frac(), 1'b0, '0);
						if ($urandom_range(0, 15) == 0)
							offer(CMD_UNKNOWN, FIELD_BITS'($urandom), RAND_BITS'($urandom),
								1'b0, '0);
					end
				end
				endcase
			end
		end

		settle();
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
